>>> rtl/tgeb_pkg.sv
// Package with the shared widths, slot codes and control types of the event builder.
package tgeb_pkg;

    // Field widths of one hit and one slot record.
    localparam int CHAN_W   = 3;
    localparam int TIME_W   = 48;
    localparam int ENERGY_W = 16;
    localparam int EVENT_W  = 32;
    localparam int CFG_W    = 32;

    // Slot layout: detectors first, then the RF slot, then the tagger slot.
    localparam int DETECTOR_COUNT = 4;
    localparam int SLOT_COUNT     = DETECTOR_COUNT + 2;
    localparam int DET_IDX_W      = $clog2(DETECTOR_COUNT);
    localparam logic [CHAN_W-1:0] RF_SLOT   = CHAN_W'(DETECTOR_COUNT);
    localparam logic [CHAN_W-1:0] TAG_SLOT  = CHAN_W'(DETECTOR_COUNT + 1);
    localparam logic [CHAN_W-1:0] LAST_SLOT = CHAN_W'(SLOT_COUNT - 1);

    // Gap window: the register counts units of ten ticks.
    localparam int GAP_DIVISOR = 10;
    localparam int GAP_RESET   = 1000;
    localparam int LIMIT_W     = 36;
    // Tick threshold for the reset window: gap/10 > w holds exactly when gap > 10*w + 9.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET =
        LIMIT_W'(GAP_RESET * GAP_DIVISOR + GAP_DIVISOR - 1);

    // Request from the builder to the record emitter to take a closed event.
    typedef struct packed {
        logic                    valid;
        logic [SLOT_COUNT-1:0]   filled;
        logic [EVENT_W-1:0]      event_number;
    } t_close_req;

endpackage

>>> rtl/tgeb_if.sv
// Valid/ready channel interfaces for hits in and slot records out.
interface tgeb_hit_if;
    logic                            valid;
    logic                            ready;
    logic [tgeb_pkg::CHAN_W-1:0]     channel;
    logic [tgeb_pkg::TIME_W-1:0]     timestamp;
    logic [tgeb_pkg::TIME_W-1:0]     fast_time;
    logic [tgeb_pkg::ENERGY_W-1:0]   slow_energy;
    logic [tgeb_pkg::TIME_W-1:0]     slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]   fast_energy;

    modport source (
        output valid, channel, timestamp, fast_time, slow_energy, slow_time, fast_energy,
        input  ready
    );
    modport sink (
        input  valid, channel, timestamp, fast_time, slow_energy, slow_time, fast_energy,
        output ready
    );
endinterface

interface tgeb_rec_if;
    logic                            valid;
    logic                            ready;
    logic [tgeb_pkg::CHAN_W-1:0]     slot;
    logic                            present;
    logic [tgeb_pkg::TIME_W-1:0]     hit_fast_time;
    logic [tgeb_pkg::ENERGY_W-1:0]   hit_slow_energy;
    logic [tgeb_pkg::TIME_W-1:0]     hit_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]   hit_fast_energy;
    logic [tgeb_pkg::EVENT_W-1:0]    event_number;
    logic                            last_in_event;

    modport source (
        output valid, slot, present, hit_fast_time, hit_slow_energy, hit_slow_time,
               hit_fast_energy, event_number, last_in_event,
        input  ready
    );
    modport sink (
        input  valid, slot, present, hit_fast_time, hit_slow_energy, hit_slow_time,
               hit_fast_energy, event_number, last_in_event,
        output ready
    );
endinterface

>>> rtl/tgeb_hit_stage.sv
// Input register that holds one hit until the builder consumes it.
module tgeb_hit_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tgeb_hit_if.sink                        i_hit,
    input  logic                            i_consume,
    output logic                            o_valid,
    output logic [tgeb_pkg::CHAN_W-1:0]     o_channel,
    output logic [tgeb_pkg::TIME_W-1:0]     o_timestamp,
    output logic [tgeb_pkg::TIME_W-1:0]     o_fast_time,
    output logic [tgeb_pkg::ENERGY_W-1:0]   o_slow_energy,
    output logic [tgeb_pkg::TIME_W-1:0]     o_slow_time,
    output logic [tgeb_pkg::ENERGY_W-1:0]   o_fast_energy
);

    logic                            r_valid;
    logic                            n_valid;
    logic                            take;
    logic [tgeb_pkg::CHAN_W-1:0]     r_channel;
    logic [tgeb_pkg::TIME_W-1:0]     r_timestamp;
    logic [tgeb_pkg::TIME_W-1:0]     r_fast_time;
    logic [tgeb_pkg::ENERGY_W-1:0]   r_slow_energy;
    logic [tgeb_pkg::TIME_W-1:0]     r_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]   r_fast_energy;

    // The register takes a new request when empty or when its hit leaves this cycle.
    assign i_hit.ready = !r_valid || i_consume;
    assign take        = i_hit.valid && i_hit.ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_consume) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hit payload, loaded with each accepted request.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_channel     <= i_hit.channel;
            r_timestamp   <= i_hit.timestamp;
            r_fast_time   <= i_hit.fast_time;
            r_slow_energy <= i_hit.slow_energy;
            r_slow_time   <= i_hit.slow_time;
            r_fast_energy <= i_hit.fast_energy;
        end
    end

    assign o_valid       = r_valid;
    assign o_channel     = r_channel;
    assign o_timestamp   = r_timestamp;
    assign o_fast_time   = r_fast_time;
    assign o_slow_energy = r_slow_energy;
    assign o_slow_time   = r_slow_time;
    assign o_fast_energy = r_fast_energy;

endmodule

>>> rtl/tgeb_builder.sv
// Gap check against the window, open-event slot store and event close request.
module tgeb_builder (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_cfg_we,
    input  logic [tgeb_pkg::CFG_W-1:0]                          i_cfg_wdata,
    input  logic                                                i_valid,
    input  logic [tgeb_pkg::CHAN_W-1:0]                         i_channel,
    input  logic [tgeb_pkg::TIME_W-1:0]                         i_timestamp,
    input  logic [tgeb_pkg::TIME_W-1:0]                         i_fast_time,
    input  logic [tgeb_pkg::ENERGY_W-1:0]                       i_slow_energy,
    input  logic [tgeb_pkg::TIME_W-1:0]                         i_slow_time,
    input  logic [tgeb_pkg::ENERGY_W-1:0]                       i_fast_energy,
    output logic                                                o_consume,
    output tgeb_pkg::t_close_req                                o_close,
    input  logic                                                i_close_ready,
    output logic [tgeb_pkg::SLOT_COUNT-1:0][tgeb_pkg::TIME_W-1:0]       o_fast_time,
    output logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::ENERGY_W-1:0] o_slow_energy,
    output logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::TIME_W-1:0]   o_slow_time,
    output logic [tgeb_pkg::ENERGY_W-1:0]                       o_tag_energy
);

    logic [tgeb_pkg::LIMIT_W-1:0]                               r_limit;
    logic [tgeb_pkg::TIME_W-1:0]                                r_prev_ts;
    logic                                                       r_seen;
    logic [tgeb_pkg::SLOT_COUNT-1:0]                            r_filled;
    logic [tgeb_pkg::EVENT_W-1:0]                               r_event_count;
    logic [tgeb_pkg::SLOT_COUNT-1:0]                            n_filled;
    logic [tgeb_pkg::SLOT_COUNT-1:0][tgeb_pkg::TIME_W-1:0]      r_fast_time;
    logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::ENERGY_W-1:0] r_slow_energy;
    logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::TIME_W-1:0]  r_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              r_tag_energy;
    logic [tgeb_pkg::TIME_W:0]                                  diff;
    logic                                                       close;
    logic [tgeb_pkg::SLOT_COUNT-1:0]                            base_filled;
    logic [tgeb_pkg::SLOT_COUNT-1:0]                            wr_slot;

    // A gap closes the event when gap/10 exceeds the window, i.e. gap > 10*window + 9.
    assign diff  = {1'b0, i_timestamp} - {1'b0, r_prev_ts};
    assign close = i_valid && r_seen && !diff[tgeb_pkg::TIME_W]
                   && (diff[tgeb_pkg::TIME_W-1:0] > tgeb_pkg::TIME_W'(r_limit));

    // A closing hit waits until the emitter can take the finished event.
    assign o_consume = i_valid && (!close || i_close_ready);

    // Slot capture: the closing hit lands in a freshly cleared event.
    always_comb begin
        base_filled = close ? '0 : r_filled;
        wr_slot     = '0;
        for (int s = 0; s < tgeb_pkg::SLOT_COUNT; s++) begin
            wr_slot[s] = o_consume && (i_channel == tgeb_pkg::CHAN_W'(s)) && !base_filled[s];
        end
        n_filled = base_filled | wr_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= tgeb_pkg::LIMIT_RESET;
            r_prev_ts     <= '0;
            r_seen        <= 1'b0;
            r_filled      <= '0;
            r_event_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= tgeb_pkg::LIMIT_W'(i_cfg_wdata)
                           * tgeb_pkg::LIMIT_W'(tgeb_pkg::GAP_DIVISOR)
                           + tgeb_pkg::LIMIT_W'(tgeb_pkg::GAP_DIVISOR - 1);
            end
            if (o_consume) begin
                r_prev_ts <= i_timestamp;
                r_seen    <= 1'b1;
                r_filled  <= n_filled;
                if (close) begin
                    r_event_count <= r_event_count + 1'b1;
                end
            end
        end
    end

    // Captured values of the first hit of each slot.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < tgeb_pkg::SLOT_COUNT; s++) begin
            if (wr_slot[s]) begin
                r_fast_time[s] <= i_fast_time;
            end
        end
        for (int d = 0; d < tgeb_pkg::DETECTOR_COUNT; d++) begin
            if (wr_slot[d]) begin
                r_slow_energy[d] <= i_slow_energy;
                r_slow_time[d]   <= i_slow_time;
            end
        end
        if (wr_slot[tgeb_pkg::TAG_SLOT]) begin
            r_tag_energy <= i_fast_energy;
        end
    end

    // The closed event is offered with the store contents before this hit's write.
    assign o_close.valid        = close;
    assign o_close.filled       = r_filled;
    assign o_close.event_number = r_event_count;
    assign o_fast_time          = r_fast_time;
    assign o_slow_energy        = r_slow_energy;
    assign o_slow_time          = r_slow_time;
    assign o_tag_energy         = r_tag_energy;

endmodule

>>> rtl/tgeb_emitter.sv
// Holds one closed event and sends its six slot records through an output register.
module tgeb_emitter (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  tgeb_pkg::t_close_req                                i_close,
    output logic                                                o_close_ready,
    input  logic [tgeb_pkg::SLOT_COUNT-1:0][tgeb_pkg::TIME_W-1:0]       i_fast_time,
    input  logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::ENERGY_W-1:0] i_slow_energy,
    input  logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::TIME_W-1:0]   i_slow_time,
    input  logic [tgeb_pkg::ENERGY_W-1:0]                       i_tag_energy,
    tgeb_rec_if.source                                          o_rec
);

    logic                                                       r_snap_valid;
    logic [tgeb_pkg::SLOT_COUNT-1:0]                            r_snap_filled;
    logic [tgeb_pkg::EVENT_W-1:0]                               r_snap_event;
    logic [tgeb_pkg::SLOT_COUNT-1:0][tgeb_pkg::TIME_W-1:0]      r_snap_fast_time;
    logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::ENERGY_W-1:0] r_snap_slow_energy;
    logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::TIME_W-1:0]  r_snap_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              r_snap_tag_energy;
    logic [tgeb_pkg::CHAN_W-1:0]                                r_idx;
    logic                                                       r_out_valid;
    logic                                                       n_out_valid;
    logic                                                       take_snap;
    logic                                                       load;
    logic                                                       is_last;
    logic                                                       is_det;
    logic                                                       pres;
    logic [tgeb_pkg::CHAN_W-1:0]                                r_slot;
    logic                                                       r_present;
    logic [tgeb_pkg::TIME_W-1:0]                                r_fast_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              r_slow_energy;
    logic [tgeb_pkg::TIME_W-1:0]                                r_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              r_fast_energy;
    logic [tgeb_pkg::EVENT_W-1:0]                               r_event_number;
    logic                                                       r_last;

    // The event buffer is free only once all six records have left it.
    assign o_close_ready = !r_snap_valid;
    assign take_snap     = i_close.valid && !r_snap_valid;

    // A record moves into the output register when it is empty or being taken.
    assign load    = r_snap_valid && (!r_out_valid || o_rec.ready);
    assign is_last = (r_idx == tgeb_pkg::LAST_SLOT);
    assign is_det  = (r_idx < tgeb_pkg::CHAN_W'(tgeb_pkg::DETECTOR_COUNT));
    assign pres    = r_snap_filled[r_idx];

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rec.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take_snap) begin
                r_snap_valid <= 1'b1;
            end else if (load && is_last) begin
                r_snap_valid <= 1'b0;
            end
            if (load) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Snapshot of the closed event.
    always_ff @(posedge i_clk) begin
        if (take_snap) begin
            r_snap_filled      <= i_close.filled;
            r_snap_event       <= i_close.event_number;
            r_snap_fast_time   <= i_fast_time;
            r_snap_slow_energy <= i_slow_energy;
            r_snap_slow_time   <= i_slow_time;
            r_snap_tag_energy  <= i_tag_energy;
        end
    end

    // Record assembly: absent slots and fields that do not apply read as zero.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot         <= r_idx;
            r_present      <= pres;
            r_fast_time    <= pres ? r_snap_fast_time[r_idx] : '0;
            r_slow_energy  <= (pres && is_det)
                              ? r_snap_slow_energy[r_idx[tgeb_pkg::DET_IDX_W-1:0]] : '0;
            r_slow_time    <= (pres && is_det)
                              ? r_snap_slow_time[r_idx[tgeb_pkg::DET_IDX_W-1:0]] : '0;
            r_fast_energy  <= (pres && (r_idx == tgeb_pkg::TAG_SLOT))
                              ? r_snap_tag_energy : '0;
            r_event_number <= r_snap_event;
            r_last         <= is_last;
        end
    end

    assign o_rec.valid           = r_out_valid;
    assign o_rec.slot            = r_slot;
    assign o_rec.present         = r_present;
    assign o_rec.hit_fast_time   = r_fast_time;
    assign o_rec.hit_slow_energy = r_slow_energy;
    assign o_rec.hit_slow_time   = r_slow_time;
    assign o_rec.hit_fast_energy = r_fast_energy;
    assign o_rec.event_number    = r_event_number;
    assign o_rec.last_in_event   = r_last;

endmodule

>>> rtl/time_gap_event_builder_unit.sv
// Top level of the time-gap event builder: hit register, builder and record emitter.
// One hit per cycle unless stalled; a hit is registered on acceptance and processed the next cycle.
// A hit that closes an event passes the hit register and the event buffer before slot record 0
// enters the output register; records 1 to 5 follow one per cycle while the sink takes them.
// The emitter buffers one closed event, so a closing hit stalls until the previous
// event's six records have been loaded into the output register.
// Synchronous reset clears control state and sets the gap window to 1000; slot data is not cleared.
module time_gap_event_builder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tgeb_pkg::CFG_W-1:0]      i_cfg_wdata,
    tgeb_hit_if.sink                        i_hit,
    tgeb_rec_if.source                      o_rec
);

    logic                                                       hit_valid;
    logic                                                       consume;
    logic [tgeb_pkg::CHAN_W-1:0]                                hit_channel;
    logic [tgeb_pkg::TIME_W-1:0]                                hit_timestamp;
    logic [tgeb_pkg::TIME_W-1:0]                                hit_fast_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              hit_slow_energy;
    logic [tgeb_pkg::TIME_W-1:0]                                hit_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              hit_fast_energy;
    tgeb_pkg::t_close_req                                       close_req;
    logic                                                       close_ready;
    logic [tgeb_pkg::SLOT_COUNT-1:0][tgeb_pkg::TIME_W-1:0]      store_fast_time;
    logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::ENERGY_W-1:0] store_slow_energy;
    logic [tgeb_pkg::DETECTOR_COUNT-1:0][tgeb_pkg::TIME_W-1:0]  store_slow_time;
    logic [tgeb_pkg::ENERGY_W-1:0]                              store_tag_energy;

    // Input register for the hit channel.
    tgeb_hit_stage u_hit_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hit         (i_hit),
        .i_consume     (consume),
        .o_valid       (hit_valid),
        .o_channel     (hit_channel),
        .o_timestamp   (hit_timestamp),
        .o_fast_time   (hit_fast_time),
        .o_slow_energy (hit_slow_energy),
        .o_slow_time   (hit_slow_time),
        .o_fast_energy (hit_fast_energy)
    );

    // Gap check and open-event store.
    tgeb_builder u_builder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (hit_valid),
        .i_channel     (hit_channel),
        .i_timestamp   (hit_timestamp),
        .i_fast_time   (hit_fast_time),
        .i_slow_energy (hit_slow_energy),
        .i_slow_time   (hit_slow_time),
        .i_fast_energy (hit_fast_energy),
        .o_consume     (consume),
        .o_close       (close_req),
        .i_close_ready (close_ready),
        .o_fast_time   (store_fast_time),
        .o_slow_energy (store_slow_energy),
        .o_slow_time   (store_slow_time),
        .o_tag_energy  (store_tag_energy)
    );

    // Closed-event buffer and record output register.
    tgeb_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_close       (close_req),
        .o_close_ready (close_ready),
        .i_fast_time   (store_fast_time),
        .i_slow_energy (store_slow_energy),
        .i_slow_time   (store_slow_time),
        .i_tag_energy  (store_tag_energy),
        .o_rec         (o_rec)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the time-gap event builder: directed and random hit streams.
module tb_top;
    import tgeb_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 17;
    localparam int MAX_PRINTED   = 40;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_HITS    = 28;

    localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [CFG_W-1:0]    WINDOW_MAX = '1;

    // Channels past the tagger slot are accepted but never captured.
    localparam logic [CHAN_W-1:0] CH_SPARE_LO = CHAN_W'(SLOT_COUNT);
    localparam logic [CHAN_W-1:0] CH_SPARE_HI = CHAN_W'(SLOT_COUNT + 1);

    typedef struct {
        logic [CHAN_W-1:0]   channel;
        logic [TIME_W-1:0]   timestamp;
        logic [TIME_W-1:0]   fast_time;
        logic [ENERGY_W-1:0] slow_energy;
        logic [TIME_W-1:0]   slow_time;
        logic [ENERGY_W-1:0] fast_energy;
    } hit_t;

    typedef struct {
        logic [CHAN_W-1:0]   slot;
        logic                present;
        logic [TIME_W-1:0]   hit_fast_time;
        logic [ENERGY_W-1:0] hit_slow_energy;
        logic [TIME_W-1:0]   hit_slow_time;
        logic [ENERGY_W-1:0] hit_fast_energy;
        logic [EVENT_W-1:0]  event_number;
        logic                last_in_event;
    } slot_rec_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    tgeb_hit_if hit_ch ();
    tgeb_rec_if rec_ch ();

    time_gap_event_builder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_hit       (hit_ch),
        .o_rec       (rec_ch)
    );

    // Bench control shared by the test tasks and the two handshake processes.
    int          cycle_count   = 0;
    int          mismatch_count = 0;
    int          rec_hold_left = 0;
    bit          hit_idle_en   = 1'b1;
    bit          rec_idle_en   = 1'b1;
    logic [TIME_W-1:0] last_sent_ts;

    // Event model: open event contents, gap window and the records it owes.
    logic [CFG_W-1:0]    model_window;
    logic [TIME_W-1:0]   model_prev_ts;
    logic                model_seen;
    logic [SLOT_COUNT-1:0] model_filled;
    logic [TIME_W-1:0]   model_fast_time [SLOT_COUNT];
    logic [ENERGY_W-1:0] model_slow_energy [DETECTOR_COUNT];
    logic [TIME_W-1:0]   model_slow_time [DETECTOR_COUNT];
    logic [ENERGY_W-1:0] model_tag_energy;
    logic [EVENT_W-1:0]  model_event_count;
    slot_rec_t           pending_records [$];
    slot_rec_t           want_rec;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit: a hung block ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void reset_event_model();
        model_window      = CFG_W'(GAP_RESET);
        model_prev_ts     = '0;
        model_seen        = 1'b0;
        model_filled      = '0;
        model_tag_energy  = '0;
        model_event_count = '0;
        for (int s = 0; s < SLOT_COUNT; s++) model_fast_time[s] = '0;
        for (int d = 0; d < DETECTOR_COUNT; d++) begin
            model_slow_energy[d] = '0;
            model_slow_time[d]   = '0;
        end
    endfunction

    // Apply one accepted hit: close the open event if the gap is too large, then capture.
    function automatic void fold_hit_into_event(input hit_t h);
        logic [TIME_W-1:0] gap_units;
        slot_rec_t         r;
        int                ch;
        gap_units = '0;
        ch        = int'(h.channel);
        if (model_seen && h.timestamp > model_prev_ts)
            gap_units = (h.timestamp - model_prev_ts) / TIME_W'(GAP_DIVISOR);
        if (gap_units > TIME_W'(model_window)) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r.slot            = CHAN_W'(s);
                r.present         = model_filled[s];
                r.hit_fast_time   = model_filled[s] ? model_fast_time[s] : '0;
                r.hit_slow_energy = '0;
                r.hit_slow_time   = '0;
                if (model_filled[s] && s < DETECTOR_COUNT) begin
                    r.hit_slow_energy = model_slow_energy[s];
                    r.hit_slow_time   = model_slow_time[s];
                end
                r.hit_fast_energy = (model_filled[s] && CHAN_W'(s) == TAG_SLOT) ?
                                    model_tag_energy : '0;
                r.event_number    = model_event_count;
                r.last_in_event   = (CHAN_W'(s) == LAST_SLOT);
                pending_records   = {pending_records, r};
            end
            model_event_count = model_event_count + 1'b1;
            model_filled      = '0;
        end
        // Only the first hit of each slot in an event is kept.
        if (ch < SLOT_COUNT && !model_filled[ch]) begin
            model_filled[ch]    = 1'b1;
            model_fast_time[ch] = h.fast_time;
            if (ch < DETECTOR_COUNT) begin
                model_slow_energy[ch] = h.slow_energy;
                model_slow_time[ch]   = h.slow_time;
            end else if (h.channel == TAG_SLOT) begin
                model_tag_energy = h.fast_energy;
            end
        end
        model_prev_ts = h.timestamp;
        model_seen    = 1'b1;
    endfunction

    function automatic hit_t make_hit(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] ts,
                                      input logic [TIME_W-1:0] ft, input logic [ENERGY_W-1:0] se,
                                      input logic [TIME_W-1:0] st, input logic [ENERGY_W-1:0] fe);
        hit_t h;
        h.channel     = ch;
        h.timestamp   = ts;
        h.fast_time   = ft;
        h.slow_energy = se;
        h.slow_time   = st;
        h.fast_energy = fe;
        return h;
    endfunction

    function automatic hit_t random_hit(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] ts);
        return make_hit(ch, ts, TIME_W'({$urandom, $urandom}), ENERGY_W'($urandom),
                        TIME_W'({$urandom, $urandom}), ENERGY_W'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Offer one hit request and hold it until the block takes it.
    task automatic send_hit(input hit_t h);
        @(negedge i_clk);
        while (hit_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            hit_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        hit_ch.valid       = 1'b1;
        hit_ch.channel     = h.channel;
        hit_ch.timestamp   = h.timestamp;
        hit_ch.fast_time   = h.fast_time;
        hit_ch.slow_energy = h.slow_energy;
        hit_ch.slow_time   = h.slow_time;
        hit_ch.fast_energy = h.fast_energy;
        do @(posedge i_clk); while (!hit_ch.ready);
        fold_hit_into_event(h);
        last_sent_ts = h.timestamp;
    endtask

    task automatic send_random_payload(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] ts);
        send_hit(random_hit(ch, ts));
    endtask

    // Stop offering hits and wait until every owed record is out and the block is quiet.
    task automatic wait_drained();
        @(negedge i_clk);
        hit_ch.valid = 1'b0;
        while (pending_records.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic write_gap_window(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        model_window = value;
    endtask

    // Record sink: random back-pressure plus an optional long hold-off.
    initial begin
        rec_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rec_hold_left > 0) begin
                rec_ch.ready  = 1'b0;
                rec_hold_left = rec_hold_left - 1;
            end else begin
                rec_ch.ready = !(rec_idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Record checker: each accepted record against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && rec_ch.valid && rec_ch.ready) begin
            if (pending_records.size() == 0) begin
                report_mismatch("record with none owed, slot", 64'(rec_ch.slot), 64'd0);
            end else begin
                want_rec = pending_records.pop_front();
                compare_field("slot", 64'(rec_ch.slot), 64'(want_rec.slot));
                compare_field("present", 64'(rec_ch.present), 64'(want_rec.present));
                compare_field("hit_fast_time", 64'(rec_ch.hit_fast_time),
                              64'(want_rec.hit_fast_time));
                compare_field("hit_slow_energy", 64'(rec_ch.hit_slow_energy),
                              64'(want_rec.hit_slow_energy));
                compare_field("hit_slow_time", 64'(rec_ch.hit_slow_time),
                              64'(want_rec.hit_slow_time));
                compare_field("hit_fast_energy", 64'(rec_ch.hit_fast_energy),
                              64'(want_rec.hit_fast_energy));
                compare_field("event_number", 64'(rec_ch.event_number),
                              64'(want_rec.event_number));
                compare_field("last_in_event", 64'(rec_ch.last_in_event),
                              64'(want_rec.last_in_event));
            end
        end
    end

    // First hit after reset, every channel, repeat hits and extreme payloads.
    task automatic test_channels_and_first_hit();
        send_hit(make_hit(3'd0, '0, TIME_MAX, ENERGY_MAX, TIME_MAX, ENERGY_MAX));
        send_hit(make_hit(3'd1, TIME_W'(5), '0, '0, '0, '0));
        for (int c = 2; c <= int'(TAG_SLOT); c++)
            send_random_payload(CHAN_W'(c), last_sent_ts + TIME_W'(10));
        send_random_payload(CH_SPARE_LO, last_sent_ts + TIME_W'(1));
        send_random_payload(CH_SPARE_HI, last_sent_ts + TIME_W'(1));
        // A second detector 0 hit must not replace the first one.
        send_random_payload(3'd0, last_sent_ts + TIME_W'(3));
        send_random_payload(3'd3, last_sent_ts + TIME_W'(GAP_RESET * GAP_DIVISOR + GAP_DIVISOR));
    endtask

    // Gap exactly at the window, a backwards timestamp, and events closed by spare channels.
    task automatic test_gap_edges();
        send_random_payload(RF_SLOT, last_sent_ts + TIME_W'(GAP_RESET * GAP_DIVISOR + 9));
        send_random_payload(TAG_SLOT, last_sent_ts - TIME_W'(500));
        send_random_payload(CH_SPARE_HI,
                            last_sent_ts + TIME_W'(GAP_RESET * GAP_DIVISOR + GAP_DIVISOR));
        // This event holds only a spare-channel hit, so all six slots come out empty.
        send_random_payload(CH_SPARE_LO,
                            last_sent_ts + TIME_W'(GAP_RESET * GAP_DIVISOR + GAP_DIVISOR));
        wait_drained();
    endtask

    // Smallest and largest windows, with timestamps at both ends of their range.
    task automatic test_window_extremes();
        write_gap_window('0);
        send_random_payload(3'd2, last_sent_ts + TIME_W'(9));
        send_random_payload(3'd1, last_sent_ts + TIME_W'(GAP_DIVISOR));
        send_random_payload(3'd0, TIME_MAX);
        send_random_payload(TAG_SLOT, '0);
        wait_drained();
        write_gap_window(WINDOW_MAX);
        send_random_payload(RF_SLOT, last_sent_ts + TIME_W'(64'(WINDOW_MAX) * 10 + 9));
        send_random_payload(3'd3, last_sent_ts + TIME_W'(64'(WINDOW_MAX) * 10 + 10));
        send_random_payload(3'd1, TIME_MAX);
        wait_drained();
    endtask

    // Sink holds off for a long stretch while closing hits keep coming, so the input stalls.
    task automatic test_output_backpressure();
        write_gap_window('0);
        hit_idle_en = 1'b0;
        @(posedge i_clk);
        rec_hold_left = HOLD_CYCLES;
        for (int n = 0; n < 12; n++)
            send_random_payload(CHAN_W'($urandom_range(0, SLOT_COUNT - 1)),
                                last_sent_ts + TIME_W'(GAP_DIVISOR + $urandom_range(0, 5)));
        hit_idle_en = 1'b1;
        wait_drained();
    endtask

    // Random streams under several windows: mostly steps inside the window, mixed with closing gaps.
    task automatic test_random_streams();
        logic [CFG_W-1:0]  windows [5];
        logic [63:0]       inside_max;
        logic [63:0]       step;
        logic [TIME_W-1:0] ts;
        logic [CHAN_W-1:0] ch;
        int                pick;
        windows[0] = CFG_W'(3);
        windows[1] = '0;
        windows[2] = CFG_W'(GAP_RESET);
        windows[3] = CFG_W'($urandom_range(1, 200));
        windows[4] = WINDOW_MAX;
        for (int p = 0; p < 5; p++) begin
            write_gap_window(windows[p]);
            inside_max = 64'(windows[p]) * 10 + 9;
            // One phase runs with neither side idling.
            hit_idle_en = (p != 2);
            rec_idle_en = (p != 2);
            for (int n = 0; n < PHASE_HITS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    step = ($urandom_range(0, 99) < 10) ? inside_max :
                           {$urandom, $urandom} % (inside_max + 1);
                    ts = last_sent_ts + TIME_W'(step);
                end else if (pick < 85) begin
                    ts = last_sent_ts + TIME_W'(inside_max + 1 + 64'($urandom_range(0, 20)));
                end else if (pick < 92) begin
                    ts = last_sent_ts - TIME_W'($urandom_range(0, 1000));
                end else begin
                    ts = TIME_W'({$urandom, $urandom});
                end
                ch = ($urandom_range(0, 99) < 88) ? CHAN_W'($urandom_range(0, SLOT_COUNT - 1)) :
                     CHAN_W'($urandom_range(int'(CH_SPARE_LO), int'(CH_SPARE_HI)));
                send_random_payload(ch, ts);
            end
            wait_drained();
        end
        hit_idle_en = 1'b1;
        rec_idle_en = 1'b1;
    endtask

    // Main sequence.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        hit_ch.valid       = 1'b0;
        hit_ch.channel     = '0;
        hit_ch.timestamp   = '0;
        hit_ch.fast_time   = '0;
        hit_ch.slow_energy = '0;
        hit_ch.slow_time   = '0;
        hit_ch.fast_energy = '0;
        last_sent_ts       = '0;
        reset_event_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_channels_and_first_hit();
        test_gap_edges();
        test_window_extremes();
        test_output_backpressure();
        test_random_streams();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/tgeb_pkg.sv
rtl/tgeb_if.sv
rtl/tgeb_hit_stage.sv
rtl/tgeb_builder.sv
rtl/tgeb_emitter.sv
rtl/time_gap_event_builder_unit.sv
bench/tb_top.sv
